### sv/block_buffer_cache_table_core_defines.svh
// Assertion macros used by the port-level checker of the buffer cache table.
`ifndef BLOCK_BUFFER_CACHE_TABLE_CORE_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbc assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbc assertion failed");

`endif

### sv/bbc_pkg.sv
// Package: types, constants and codes for the buffer cache table.
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int NUM_BUFFERS = 32;
    localparam int ADDR_W      = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int RANGE_W     = 9;     // holds any table size up to 511
    localparam int DEV_W       = 8;
    localparam int BLK_W       = 32;
    localparam int CNT_W       = 8;
    localparam int IDX_W       = 5;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFREE = 2'd1,
        STAT_UNDER  = 2'd2,
        STAT_SAT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MODIFY,
        BK_SCAN,
        BK_DRAIN,
        BK_DECIDE
    } bk_state_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [IDX_W-1:0] idx;
        logic             in_range;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } q_head_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] cnt;
    } entry_word_t;

    typedef struct packed {
        status_t          status;
        logic             needs_fill;
        logic             hit;
        logic [IDX_W-1:0] entry;
    } result_t;

endpackage

### sv/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/bbc_front.sv
// Front end: accept request words, decode and classify them, queue them.
`timescale 1ns / 1ps

module bbc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bbc_pkg::S_DATA_W-1:0]       s_tdata,
    output bbc_pkg::q_head_t                   head,
    input  logic                               pop
);

    import bbc_pkg::*;

    req_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    req_t              in_req;
    logic              push;
    logic              pop_ok;

    // Decode the incoming word and mark whether an index names a real entry.
    always_comb
    begin
        in_req.cmd      = cmd_t'(s_tdata[1:0]);
        in_req.dev      = s_tdata[9:2];
        in_req.blk      = s_tdata[41:10];
        in_req.idx      = s_tdata[46:42];
        in_req.in_range = RANGE_W'(s_tdata[46:42]) < RANGE_W'(NUM_BUFFERS);
    end

    assign s_tready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop_ok   = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.req   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_ok && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

### sv/bbc_back.sv
// Back end: sequencer that scans the entry table and updates counts and tags.
`timescale 1ns / 1ps

module bbc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bbc_pkg::q_head_t         head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output bbc_pkg::result_t         result
);

    import bbc_pkg::*;

    bk_state_t              state_reg, state_next;
    req_t                   req_reg;
    logic [ADDR_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                   rd_v_reg;
    logic [ADDR_W-1:0]      rd_idx_reg;
    logic                   match_found_reg;
    logic [ADDR_W-1:0]      match_idx_reg;
    entry_word_t            match_word_reg;
    logic                   free_found_reg;
    logic [ADDR_W-1:0]      free_idx_reg;
    logic [NUM_BUFFERS-1:0] valid_reg;
    logic [NUM_BUFFERS-1:0] init_reg;
    logic                   out_valid_reg;
    result_t                res_reg;

    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    entry_word_t            wr_data;
    logic                   set_valid;
    logic                   push;
    result_t                res_next;
    entry_word_t            ram_q;
    entry_word_t            eff_word;
    logic                   scanning;
    logic                   start;

    bbc_ram #(
        .WIDTH ($bits(entry_word_t)),
        .DEPTH (NUM_BUFFERS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // An entry never written since reset reads as all zero.
    assign eff_word = init_reg[rd_idx_reg] ? ram_q : '0;
    assign scanning = rd_v_reg && ((state_reg == BK_SCAN) || (state_reg == BK_DRAIN));
    assign start    = (state_reg == BK_IDLE) && head.valid && !out_valid_reg;

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_addr_next = scan_addr_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    scan_addr_next = '0;
                    state_next     = (head.req.cmd == CMD_GET) ? BK_SCAN : BK_READ;
                end
            end
            BK_READ:   state_next = BK_MODIFY;
            BK_MODIFY: state_next = BK_IDLE;
            BK_SCAN:
            begin
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == ADDR_W'(NUM_BUFFERS - 1))
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:  state_next = BK_DECIDE;
            BK_DECIDE: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = scan_addr_reg;
        wr_en     = 1'b0;
        wr_addr   = ADDR_W'(req_reg.idx);
        wr_data   = eff_word;
        set_valid = 1'b0;
        push      = 1'b0;
        res_next  = '{status: STAT_OK, needs_fill: 1'b0, hit: 1'b0, entry: req_reg.idx};
        case (state_reg)
            BK_IDLE:
            begin
                pop = start;
            end
            BK_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(req_reg.idx);
            end
            BK_MODIFY:
            begin
                push = 1'b1;
                if (req_reg.in_range)
                begin
                    if (req_reg.cmd == CMD_PIN)
                    begin
                        if (eff_word.cnt == COUNT_MAX)
                        begin
                            res_next.status = STAT_SAT;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_data.cnt = eff_word.cnt + 1'b1;
                        end
                    end
                    else
                    begin
                        if (eff_word.cnt == '0)
                        begin
                            res_next.status = STAT_UNDER;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_data.cnt = eff_word.cnt - 1'b1;
                        end
                    end
                end
            end
            BK_SCAN:
            begin
                rd_en = 1'b1;
            end
            BK_DECIDE:
            begin
                push = 1'b1;
                if (match_found_reg)
                begin
                    res_next.entry = IDX_W'(match_idx_reg);
                    res_next.hit   = 1'b1;
                    if (match_word_reg.cnt == COUNT_MAX)
                    begin
                        res_next.status = STAT_SAT;
                    end
                    else
                    begin
                        wr_en               = 1'b1;
                        wr_addr             = match_idx_reg;
                        wr_data             = match_word_reg;
                        wr_data.cnt         = match_word_reg.cnt + 1'b1;
                        set_valid           = 1'b1;
                        res_next.needs_fill = !valid_reg[match_idx_reg];
                    end
                end
                else if (free_found_reg)
                begin
                    wr_en               = 1'b1;
                    wr_addr             = free_idx_reg;
                    wr_data.dev         = req_reg.dev;
                    wr_data.blk         = req_reg.blk;
                    wr_data.cnt         = CNT_W'(1);
                    set_valid           = 1'b1;
                    res_next.entry      = IDX_W'(free_idx_reg);
                    res_next.needs_fill = 1'b1;
                end
                else
                begin
                    res_next.entry  = '0;
                    res_next.status = STAT_NOFREE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            scan_addr_reg   <= '0;
            rd_v_reg        <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            valid_reg       <= '0;
            init_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            rd_v_reg      <= rd_en;
            if (start)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (scanning)
            begin
                if (!match_found_reg && (eff_word.dev == req_reg.dev)
                    && (eff_word.blk == req_reg.blk))
                begin
                    match_found_reg <= 1'b1;
                end
                if (!free_found_reg && (eff_word.cnt == '0))
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                init_reg[wr_addr] <= 1'b1;
            end
            if (set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= head.req;
        end
        if (rd_en)
        begin
            rd_idx_reg <= rd_addr;
        end
        if (scanning)
        begin
            if (!match_found_reg && (eff_word.dev == req_reg.dev)
                && (eff_word.blk == req_reg.blk))
            begin
                match_idx_reg  <= rd_idx_reg;
                match_word_reg <= eff_word;
            end
            if (!free_found_reg && (eff_word.cnt == '0))
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (push)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### sv/block_buffer_cache_table_core.sv
// Top level of the buffer cache table: front end, queue and back end sequencer.
`timescale 1ns / 1ps

//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | request word: cmd, device_id, block_number, index
//  m_*     | out | m_tvalid/m_tready  | result word: entry_out, hit, needs_fill, status
//
// A get walks the whole tag RAM at one read per cycle, a rate set by the single
// read port of the tag RAM, then passes through drain and decide to the result
// register. Release, pin and unpin read one entry. Requests reach the back end
// through the two-word request queue.
// Reset clears control state and the per-entry written and valid bits; the tag
// RAM itself is not cleared, an entry never written reads as zero tags, count 0.
// The input side keeps taking words into the queue while a result waits in the
// output register; the back end starts the next word once that register is empty.

module block_buffer_cache_table_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: cmd[1:0], device_id[9:2], block_number[41:10], entry_index[46:42], zero
    input  logic [bbc_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: entry_out[4:0], hit[5], needs_fill[6], status[8:7], zero above
    output logic [bbc_pkg::M_DATA_W-1:0]     m_tdata
);

    import bbc_pkg::*;

    q_head_t head;     // queue head seen by the back end
    logic    pop;      // back end takes the head word
    result_t result;   // registered result in the back end

    // Accept, decode and queue the request words.
    bbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    // Scan or update the table and hold the result until it is taken.
    bbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // Pack the result word, lowest field first, zero fill to whole bytes.
    assign m_tdata = M_DATA_W'({result.status, result.needs_fill, result.hit, result.entry});

endmodule

### sv/bbc_checker.sv
// Port-level checker for the buffer cache table, bound to the top level.
`timescale 1ns / 1ps
`include "block_buffer_cache_table_core_defines.svh"

module bbc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [bbc_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bbc_pkg::M_DATA_W-1:0] m_tdata
);

    import bbc_pkg::*;

    logic [STAT_W-1:0] st;

    assign st = m_tdata[8:7];

    // A stalled result word holds.
    `BBC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // A table with no free entry reports zero index, no hit and no fill.
    `BBC_ASSERT_NOW(a_nofree_zero, clk, rst_n, m_tvalid && (st == STAT_NOFREE), m_tdata[6:0] == 7'd0)
    // A fill request only comes with a successful grant.
    `BBC_ASSERT_NOW(a_fill_ok, clk, rst_n, m_tvalid && m_tdata[6], st == STAT_OK)
    // Underflow comes only from release or unpin, which never hit or fill.
    `BBC_ASSERT_NOW(a_under_flags, clk, rst_n, m_tvalid && (st == STAT_UNDER), m_tdata[6:5] == 2'd0)
    // A stalled request word holds until it is taken.
    `BBC_ASSERT_NEXT(a_in_hold, clk, rst_n, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))

endmodule

bind block_buffer_cache_table_core bbc_checker u_bbc_checker (.*);

### dv/tb_block_buffer_cache_table_core.sv
// Testbench for the buffer cache table: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_block_buffer_cache_table_core;

    import bbc_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int STALL_LIMIT = 2000;  // cycles with no word accepted on either side
    localparam int DRAIN_WAIT  = 100;
    localparam int RANDOM_WORDS = 350;

    typedef struct {
        cmd_t             cmd;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [IDX_W-1:0] idx;
    } table_req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted table contents
    logic [DEV_W-1:0] tag_dev   [NUM_BUFFERS];
    logic [BLK_W-1:0] tag_blk   [NUM_BUFFERS];
    logic             tag_valid [NUM_BUFFERS];
    logic [CNT_W-1:0] ref_cnt   [NUM_BUFFERS];

    table_req_t request_q [$];
    result_t    reply_q   [$];
    table_req_t word_in_flight;
    result_t    seen_reply;
    result_t    want_reply;

    logic [DEV_W+BLK_W-1:0] hot_pairs [10];

    int words_sent   = 0;
    int words_seen   = 0;
    int total_words  = 1;
    int mismatches   = 0;
    int cycle_cnt    = 0;
    int quiet_cycles = 0;
    int idle_phase;

    assign idle_phase = (words_sent * 4) / (total_words + 1);

    block_buffer_cache_table_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t result word %0d: %s", $time, words_seen, msg);
        mismatches++;
    endtask

    // Apply one request to the predicted table and return the reply it gives.
    function automatic result_t table_apply(table_req_t r);
        result_t res;
        int      i;
        int      slot;
        res        = '0;
        res.status = STAT_OK;
        res.entry  = r.idx;
        slot       = -1;
        if (r.cmd == CMD_GET) begin
            res.entry = '0;
            // tags only, valid plays no part; lowest index wins
            for (i = 0; i < NUM_BUFFERS; i++)
                if (slot < 0 && tag_dev[i] == r.dev && tag_blk[i] == r.blk)
                    slot = i;
            if (slot >= 0) begin
                res.entry = slot[IDX_W-1:0];
                res.hit   = 1'b1;
                if (ref_cnt[slot] == COUNT_MAX) begin
                    res.status = STAT_SAT;
                end
                else begin
                    ref_cnt[slot]   = ref_cnt[slot] + 1'b1;
                    res.needs_fill  = !tag_valid[slot];
                    tag_valid[slot] = 1'b1;
                end
            end
            else begin
                for (i = 0; i < NUM_BUFFERS; i++)
                    if (slot < 0 && ref_cnt[i] == '0)
                        slot = i;
                if (slot >= 0) begin
                    tag_dev[slot]   = r.dev;
                    tag_blk[slot]   = r.blk;
                    ref_cnt[slot]   = CNT_W'(1);
                    tag_valid[slot] = 1'b1;
                    res.entry       = slot[IDX_W-1:0];
                    res.needs_fill  = 1'b1;
                end
                else begin
                    res.status = STAT_NOFREE;
                end
            end
        end
        else if (r.idx < NUM_BUFFERS) begin
            if (r.cmd == CMD_PIN) begin
                if (ref_cnt[r.idx] == COUNT_MAX)
                    res.status = STAT_SAT;
                else
                    ref_cnt[r.idx] = ref_cnt[r.idx] + 1'b1;
            end
            else begin
                if (ref_cnt[r.idx] == '0)
                    res.status = STAT_UNDER;
                else
                    ref_cnt[r.idx] = ref_cnt[r.idx] - 1'b1;
            end
        end
        return res;
    endfunction

    function automatic bit take_gap(int pct);
        return (quiet_cycles == 0) && ($urandom_range(0, 99) < pct);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 70)
            return IDX_W'($urandom_range(0, 11));
        return IDX_W'($urandom_range(0, NUM_BUFFERS - 1));
    endfunction

    function automatic cmd_t pick_lower();
        return $urandom_range(0, 1) ? CMD_RELEASE : CMD_UNPIN;
    endfunction

    // Get words carry a random index, entry operations random tags: both are ignored.
    task automatic queue_get(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
        table_req_t r;
        r.cmd = CMD_GET;
        r.dev = dev;
        r.blk = blk;
        r.idx = IDX_W'($urandom);
        request_q.push_back(r);
    endtask

    task automatic queue_entry_op(cmd_t cmd, logic [IDX_W-1:0] idx);
        table_req_t r;
        r.cmd = cmd;
        r.dev = DEV_W'($urandom);
        r.blk = $urandom;
        r.idx = idx;
        request_q.push_back(r);
    endtask

    // Driver: predict each accepted word, then present the next one.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                tag_dev[i]   = '0;
                tag_blk[i]   = '0;
                tag_valid[i] = 1'b0;
                ref_cnt[i]   = '0;
            end
        end
        else begin
            if (s_tvalid && s_tready) begin
                reply_q.push_back(table_apply(word_in_flight));
                words_sent <= words_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (request_q.size() != 0 &&
                    !take_gap(idle_phase == 1 ? 61 : (idle_phase == 3 ? 31 : 0))) begin
                    word_in_flight = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, word_in_flight.idx, word_in_flight.blk,
                                 word_in_flight.dev, word_in_flight.cmd};
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                seen_reply = result_t'(m_tdata[8:0]);
                if (reply_q.size() == 0) begin
                    report_mismatch($sformatf("word %0h with nothing outstanding", m_tdata));
                end
                else begin
                    want_reply = reply_q.pop_front();
                    if (seen_reply.entry !== want_reply.entry)
                        report_mismatch($sformatf("entry_out %0d, expected %0d",
                                                  seen_reply.entry, want_reply.entry));
                    if (seen_reply.hit !== want_reply.hit)
                        report_mismatch($sformatf("hit %0b, expected %0b",
                                                  seen_reply.hit, want_reply.hit));
                    if (seen_reply.needs_fill !== want_reply.needs_fill)
                        report_mismatch($sformatf("needs_fill %0b, expected %0b",
                                                  seen_reply.needs_fill, want_reply.needs_fill));
                    if (seen_reply.status !== want_reply.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  seen_reply.status, want_reply.status));
                    if (m_tdata[M_DATA_W-1:9] !== '0)
                        report_mismatch($sformatf("pad bits %0h not zero",
                                                  m_tdata[M_DATA_W-1:9]));
                end
                words_seen <= words_seen + 1;
            end
            m_tready <= !take_gap(idle_phase == 2 ? 61 : (idle_phase == 3 ? 31 : 0));
        end
    end

    // Watchdog; also open a run of cycles with no gaps on either side now and then.
    always @(posedge clk) begin
        if (quiet_cycles != 0)
            quiet_cycles <= quiet_cycles - 1;
        else if ($urandom_range(0, 199) == 0)
            quiet_cycles <= $urandom_range(20, 60);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            cycle_cnt <= 0;
        else if (cycle_cnt >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        int                     base;
        int                     n;
        int                     kind;
        logic [DEV_W+BLK_W-1:0] pair;

        // Directed: reset tags are all zero, so device 0 block 0 hits entry 0
        queue_get(8'h00, 32'h0000_0000);            // hit, needs fill
        queue_get(8'h00, 32'h0000_0000);            // hit, already valid
        queue_get(8'hFF, 32'hFFFF_FFFF);            // miss -> entry 1
        queue_get(8'hA5, 32'h5A5A_5A5A);            // miss -> entry 2
        queue_get(8'h00, 32'h0000_0000);            // entry 0 count 3
        queue_entry_op(CMD_RELEASE, 5'd0);
        queue_entry_op(CMD_UNPIN, 5'd0);
        queue_entry_op(CMD_RELEASE, 5'd0);          // count back to zero
        queue_entry_op(CMD_UNPIN, 5'd0);            // underflow
        queue_get(8'h5A, 32'hA5A5_A5A5);            // miss retags entry 0
        queue_get(8'h00, 32'h0000_0000);            // now matches entry 3, never valid
        queue_entry_op(CMD_PIN, 5'd31);
        queue_entry_op(CMD_PIN, 5'd31);
        queue_entry_op(CMD_UNPIN, 5'd31);
        queue_entry_op(CMD_RELEASE, 5'd31);
        queue_entry_op(CMD_RELEASE, 5'd31);         // underflow at top index
        queue_entry_op(CMD_PIN, 5'd0);
        queue_entry_op(CMD_RELEASE, 5'd0);
        queue_entry_op(CMD_RELEASE, 5'd0);
        queue_entry_op(CMD_RELEASE, 5'd1);
        queue_entry_op(CMD_UNPIN, 5'd2);
        queue_entry_op(CMD_RELEASE, 5'd3);
        queue_entry_op(CMD_UNPIN, 5'd3);            // all counts are zero again

        // Saturate: a fresh pair lands in entry 0, then hits until the count tops out
        pair = {DEV_W'($urandom), $urandom | 32'h1};
        repeat (258) queue_get(pair[DEV_W+BLK_W-1:BLK_W], pair[BLK_W-1:0]);
        repeat (2) queue_entry_op(CMD_PIN, 5'd0);
        repeat (256) queue_entry_op(pick_lower(), 5'd0);

        foreach (hot_pairs[i])
            hot_pairs[i] = {DEV_W'($urandom), $urandom};
        hot_pairs[0] = '1;
        hot_pairs[1] = '0;

        base = request_q.size();
        kind = 95;                                  // open with a fill and drain
        while (request_q.size() - base < RANDOM_WORDS) begin
            if (kind < 45) begin
                // working set: gets mostly from the ten hot pairs, then as many releases or unpins
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        pair = {DEV_W'($urandom), $urandom};
                    else
                        pair = hot_pairs[$urandom_range(0, 9)];
                    queue_get(pair[DEV_W+BLK_W-1:BLK_W], pair[BLK_W-1:0]);
                end
                repeat (n) queue_entry_op(pick_lower(), pick_index());
            end
            else if (kind < 70) begin
                // noise: anything the fields allow
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        queue_get(DEV_W'($urandom), $urandom);
                    else
                        queue_entry_op(cmd_t'($urandom_range(0, 3)), IDX_W'($urandom));
                end
            end
            else if (kind < 90) begin
                n = pick_index();
                queue_entry_op(CMD_PIN, IDX_W'(n));
                queue_entry_op(pick_lower(), IDX_W'(n));
            end
            else begin
                // overfill the table so a miss finds no free entry, then drain it
                repeat (NUM_BUFFERS + 2) queue_get(DEV_W'($urandom), $urandom);
                for (int i = 0; i < NUM_BUFFERS; i++)
                    repeat ($urandom_range(1, 3)) queue_entry_op(pick_lower(), IDX_W'(i));
            end
            kind = $urandom_range(0, 99);
        end
        total_words = request_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (words_sent < total_words || reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### block_buffer_cache_table_core.f
+incdir+sv
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_front.sv
sv/bbc_back.sv
sv/block_buffer_cache_table_core.sv
sv/bbc_checker.sv
dv/tb_block_buffer_cache_table_core.sv
